FILE: rtl/rc_pulse_to_led_drive_assert.svh
// Assertion macros shared by the RC pulse to LED drive design.
`ifndef RC_PULSE_TO_LED_DRIVE_ASSERT_SVH
`define RC_PULSE_TO_LED_DRIVE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define RCPL_ASSERT_NOW(label, trig, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (chk)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define RCPL_ASSERT_NEXT(label, trig, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (chk)) \
      else $error(msg);

`endif

FILE: rtl/rcpl_pkg.sv
// Shared types and constants for the RC pulse to LED drive block.
package rcpl_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int TS_FIELD_BITS     = 32;
   localparam int WIDTH_BITS        = 16;
   localparam int DUTY_BITS         = 8;
   localparam int DZ_BITS           = 10;
   localparam int CH_BITS           = 2;
   localparam int NUM_CHANNELS      = 3;
   localparam int CSR_ADDR_BITS     = 5;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [CH_BITS-1:0] CH_SWITCH     = 2'd0;
   localparam logic [CH_BITS-1:0] CH_BRIGHTNESS = 2'd1;
   localparam logic [CH_BITS-1:0] CH_COLOR      = 2'd2;

   localparam logic [DUTY_BITS-1:0]  DUTY_FULL = 8'hFF;
   localparam logic [DUTY_BITS-1:0]  DUTY_OFF  = 8'h00;
   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 16'hFFFF;

   localparam logic [WIDTH_BITS-1:0] RST_ON_THRESHOLD = 16'd1800;
   localparam logic [WIDTH_BITS-1:0] RST_PULSE_MIN    = 16'd1068;
   localparam logic [WIDTH_BITS-1:0] RST_PULSE_MAX    = 16'd1932;
   localparam logic [DZ_BITS-1:0]    RST_DEAD_ZONE    = 10'd15;
   localparam logic [WIDTH_BITS-1:0] RST_RED_END      = 16'd1354;
   localparam logic [WIDTH_BITS-1:0] RST_GREEN_START  = 16'd1355;
   localparam logic [WIDTH_BITS-1:0] RST_GREEN_END    = 16'd1641;
   localparam logic [WIDTH_BITS-1:0] RST_BLUE_START   = 16'd1642;

   // Numerator of a ramp is |x - a| * 255, which fits in 24 bits.
   localparam int NUM_BITS     = WIDTH_BITS + DUTY_BITS;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      REG_ON_THRESHOLD,
      REG_PULSE_MIN,
      REG_PULSE_MAX,
      REG_DEAD_ZONE,
      REG_RED_END,
      REG_GREEN_START,
      REG_GREEN_END,
      REG_BLUE_START
   } rcpl_reg_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] on_threshold;
      logic [WIDTH_BITS-1:0] pulse_min;
      logic [WIDTH_BITS-1:0] pulse_max;
      logic [DZ_BITS-1:0]    dead_zone;
      logic [WIDTH_BITS-1:0] red_end;
      logic [WIDTH_BITS-1:0] green_start;
      logic [WIDTH_BITS-1:0] green_end;
      logic [WIDTH_BITS-1:0] blue_start;
   } rcpl_cfg_type;

   typedef enum logic [1:0] {
      COLOR_NONE,
      COLOR_RED,
      COLOR_GREEN,
      COLOR_BLUE
   } rcpl_color_type;

   // One classified pulse: either an immediate duty or a ramp
   // map(x, a, b, c, d) with c/d equal to 0/255 (rising) or 255/0 (falling).
   typedef struct packed {
      logic [CH_BITS-1:0]    channel;
      logic                  use_map;
      logic                  falling;
      rcpl_color_type        color;
      logic [DUTY_BITS-1:0]  imm;
      logic [WIDTH_BITS-1:0] x;
      logic [WIDTH_BITS-1:0] a;
      logic [WIDTH_BITS-1:0] b;
   } rcpl_job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } rcpl_qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SETUP,
      BK_DIVIDE,
      BK_FINISH
   } rcpl_back_state_type;

endpackage

FILE: rtl/rcpl_front.sv
// Front end: edge capture, pulse width measurement and pulse classification.
module rcpl_front #(
   parameter int TIME_BITS = rcpl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rcpl_pkg::CH_BITS-1:0]         req_channel,
   input  logic                                 req_level,
   input  logic [rcpl_pkg::TS_FIELD_BITS-1:0]   req_timestamp_us,
   input  rcpl_pkg::rcpl_cfg_type               cfg,
   input  rcpl_pkg::rcpl_qstat_type             q_stat,
   output logic                                 q_push,
   output rcpl_pkg::rcpl_job_type               q_job
);

   logic [TIME_BITS-1:0] start_time_ff [rcpl_pkg::NUM_CHANNELS];
   logic [TIME_BITS-1:0] start_time_in [rcpl_pkg::NUM_CHANNELS];
   logic [rcpl_pkg::NUM_CHANNELS-1:0] start_valid_ff, start_valid_in;

   logic                                pend_ff, pend_in;
   logic [rcpl_pkg::CH_BITS-1:0]        ch_ff, ch_in;
   logic [rcpl_pkg::WIDTH_BITS-1:0]     w_ff, w_in;

   logic                                accept;
   logic                                ch_ok;
   logic [TIME_BITS-1:0]                ts;
   logic [TIME_BITS-1:0]                diff;
   logic [rcpl_pkg::WIDTH_BITS-1:0]     mid;
   logic [rcpl_pkg::WIDTH_BITS:0]       bright_floor;

   // A measured pulse waits in the width register until the queue has room.
   assign q_push    = pend_ff && !q_stat.full;
   assign req_stall = pend_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign ch_ok     = (req_channel == rcpl_pkg::CH_SWITCH) ||
                      (req_channel == rcpl_pkg::CH_BRIGHTNESS) ||
                      (req_channel == rcpl_pkg::CH_COLOR);
   assign ts        = TIME_BITS'(req_timestamp_us);
   assign diff      = ts - start_time_ff[req_channel];

   always_comb begin
      start_time_in  = start_time_ff;
      start_valid_in = start_valid_ff;
      pend_in        = pend_ff;
      ch_in          = ch_ff;
      w_in           = w_ff;
      if (q_push) begin
         pend_in = 1'b0;
      end
      if (accept && ch_ok) begin
         if (req_level) begin
            start_time_in[req_channel]  = ts;
            start_valid_in[req_channel] = 1'b1;
         end else if (start_valid_ff[req_channel]) begin
            start_valid_in[req_channel] = 1'b0;
            pend_in = 1'b1;
            ch_in   = req_channel;
            w_in    = (diff > TIME_BITS'(rcpl_pkg::WIDTH_MAX)) ?
                      rcpl_pkg::WIDTH_MAX : diff[rcpl_pkg::WIDTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_valid_ff <= '0;
         pend_ff        <= 1'b0;
      end else begin
         start_valid_ff <= start_valid_in;
         pend_ff        <= pend_in;
      end
      start_time_ff <= start_time_in;
      ch_ff         <= ch_in;
      w_ff          <= w_in;
   end

   // Classification of the held pulse into a ramp or a fixed duty.
   assign mid          = rcpl_pkg::WIDTH_BITS'(({1'b0, cfg.green_start} +
                                                {1'b0, cfg.green_end}) >> 1);
   assign bright_floor = {1'b0, cfg.pulse_min} +
                         (rcpl_pkg::WIDTH_BITS + 1)'(cfg.dead_zone);

   always_comb begin
      q_job         = '0;
      q_job.channel = ch_ff;
      q_job.x       = w_ff;
      q_job.color   = rcpl_pkg::COLOR_NONE;
      unique case (ch_ff)
         rcpl_pkg::CH_SWITCH: begin
            q_job.imm = (w_ff > cfg.on_threshold) ? rcpl_pkg::DUTY_FULL : rcpl_pkg::DUTY_OFF;
         end
         rcpl_pkg::CH_BRIGHTNESS: begin
            if ({1'b0, w_ff} > bright_floor) begin
               q_job.use_map = 1'b1;
               q_job.a       = cfg.pulse_min;
               q_job.b       = cfg.pulse_max;
            end
         end
         rcpl_pkg::CH_COLOR: begin
            if (w_ff <= cfg.red_end) begin
               q_job.use_map = 1'b1;
               q_job.falling = 1'b1;
               q_job.color   = rcpl_pkg::COLOR_RED;
               q_job.a       = cfg.pulse_min;
               q_job.b       = cfg.red_end;
            end else if (w_ff <= cfg.green_end) begin
               q_job.use_map = 1'b1;
               q_job.color   = rcpl_pkg::COLOR_GREEN;
               if (w_ff <= mid) begin
                  q_job.a = cfg.green_start;
                  q_job.b = mid;
               end else begin
                  q_job.falling = 1'b1;
                  q_job.a       = mid;
                  q_job.b       = cfg.green_end;
               end
            end else if (w_ff <= cfg.pulse_max) begin
               q_job.use_map = 1'b1;
               q_job.color   = rcpl_pkg::COLOR_BLUE;
               q_job.a       = cfg.blue_start;
               q_job.b       = cfg.pulse_max;
            end
         end
         default: begin
            q_job.imm = rcpl_pkg::DUTY_OFF;
         end
      endcase
   end

endmodule

FILE: rtl/rcpl_queue.sv
// Short job queue between the front end and the ramp engine.
module rcpl_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rcpl_pkg::rcpl_job_type   push_job,
   input  logic                     pop,
   output rcpl_pkg::rcpl_job_type   pop_job,
   output rcpl_pkg::rcpl_qstat_type stat
);

   localparam logic [rcpl_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      rcpl_pkg::QUEUE_PTR_BITS'(rcpl_pkg::QUEUE_DEPTH - 1);
   localparam logic [rcpl_pkg::QUEUE_CNT_BITS-1:0] FULL_CNT =
      rcpl_pkg::QUEUE_CNT_BITS'(rcpl_pkg::QUEUE_DEPTH);

   rcpl_pkg::rcpl_job_type                entry_ff [rcpl_pkg::QUEUE_DEPTH];
   logic [rcpl_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rcpl_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rcpl_pkg::QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FULL_CNT);
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/rcpl_back.sv
// Ramp engine: serial divider, duty state and the result register.
module rcpl_back (
   input  logic                            clock,
   input  logic                            reset,
   input  rcpl_pkg::rcpl_qstat_type        q_stat,
   input  rcpl_pkg::rcpl_job_type          q_job,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rcpl_pkg::CH_BITS-1:0]    rsp_updated_channel,
   output logic [rcpl_pkg::DUTY_BITS-1:0]  rsp_switch_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]  rsp_brightness_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]  rsp_red_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]  rsp_green_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]  rsp_blue_duty
);

   localparam int WB = rcpl_pkg::WIDTH_BITS;
   localparam int NB = rcpl_pkg::NUM_BITS;
   localparam int DB = rcpl_pkg::DUTY_BITS;
   localparam logic [rcpl_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
      rcpl_pkg::DIV_CNT_BITS'(NB - 1);

   rcpl_pkg::rcpl_back_state_type state_ff, state_in;
   rcpl_pkg::rcpl_job_type        job_ff, job_in;

   logic [WB-1:0]                       den_ff, den_in;
   logic                                den_zero_ff, den_zero_in;
   logic                                neg_ff, neg_in;
   logic [WB:0]                         rem_ff, rem_in;
   logic [NB-1:0]                       quo_ff, quo_in;
   logic [rcpl_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rcpl_pkg::CH_BITS-1:0]        chan_ff, chan_in;
   logic [DB-1:0]                       sw_ff, sw_in;
   logic [DB-1:0]                       br_ff, br_in;
   logic [DB-1:0]                       red_ff, red_in;
   logic [DB-1:0]                       grn_ff, grn_in;
   logic [DB-1:0]                       blu_ff, blu_in;

   logic                                out_free;
   logic                                xa_neg, den_neg;
   logic [WB-1:0]                       xa_mag, den_mag;
   logic [NB-1:0]                       num_mag;
   logic [WB:0]                         shifted;
   logic                                ge;
   logic [NB-1:0]                       quot;
   logic [DB-1:0]                       cval;
   logic [NB:0]                         sum;
   logic [DB-1:0]                       map_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Ramp setup: |x - a| * 255 as a shift and subtract, signs kept apart.
   assign xa_neg  = job_ff.x < job_ff.a;
   assign xa_mag  = xa_neg ? (job_ff.a - job_ff.x) : (job_ff.x - job_ff.a);
   assign den_neg = job_ff.b < job_ff.a;
   assign den_mag = den_neg ? (job_ff.a - job_ff.b) : (job_ff.b - job_ff.a);
   assign num_mag = {xa_mag, {DB{1'b0}}} - NB'(xa_mag);

   // One restoring division step per cycle.
   assign shifted = {rem_ff[WB-1:0], quo_ff[NB-1]};
   assign ge      = shifted >= {1'b0, den_ff};

   // Quotient truncated toward zero; a zero divisor leaves only the offset.
   assign quot = den_zero_ff ? '0 : quo_ff;
   assign cval = job_ff.falling ? rcpl_pkg::DUTY_FULL : rcpl_pkg::DUTY_OFF;
   assign sum  = {1'b0, quot} + (NB + 1)'(cval);

   always_comb begin
      if (!neg_ff) begin
         map_val = (sum > (NB + 1)'(rcpl_pkg::DUTY_FULL)) ? rcpl_pkg::DUTY_FULL : sum[DB-1:0];
      end else begin
         map_val = (quot > NB'(cval)) ? rcpl_pkg::DUTY_OFF : (cval - quot[DB-1:0]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      den_in       = den_ff;
      den_zero_in  = den_zero_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      chan_in      = chan_ff;
      sw_in        = sw_ff;
      br_in        = br_ff;
      red_in       = red_ff;
      grn_in       = grn_ff;
      blu_in       = blu_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         rcpl_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               state_in = q_job.use_map ? rcpl_pkg::BK_SETUP : rcpl_pkg::BK_FINISH;
            end
         end
         rcpl_pkg::BK_SETUP: begin
            den_in      = den_mag;
            den_zero_in = (den_mag == '0);
            neg_in      = xa_neg ^ den_neg ^ job_ff.falling;
            rem_in      = '0;
            quo_in      = num_mag;
            cnt_in      = '0;
            state_in    = rcpl_pkg::BK_DIVIDE;
         end
         rcpl_pkg::BK_DIVIDE: begin
            rem_in = ge ? (shifted - {1'b0, den_ff}) : shifted;
            quo_in = {quo_ff[NB-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = rcpl_pkg::BK_FINISH;
            end
         end
         rcpl_pkg::BK_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               chan_in      = job_ff.channel;
               unique case (job_ff.channel)
                  rcpl_pkg::CH_SWITCH: begin
                     sw_in = job_ff.imm;
                  end
                  rcpl_pkg::CH_BRIGHTNESS: begin
                     br_in = job_ff.use_map ? map_val : job_ff.imm;
                  end
                  default: begin
                     red_in = (job_ff.color == rcpl_pkg::COLOR_RED)   ? map_val : '0;
                     grn_in = (job_ff.color == rcpl_pkg::COLOR_GREEN) ? map_val : '0;
                     blu_in = (job_ff.color == rcpl_pkg::COLOR_BLUE)  ? map_val : '0;
                  end
               endcase
               state_in = rcpl_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = rcpl_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcpl_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         sw_ff        <= '0;
         br_ff        <= '0;
         red_ff       <= '0;
         grn_ff       <= '0;
         blu_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sw_ff        <= sw_in;
         br_ff        <= br_in;
         red_ff       <= red_in;
         grn_ff       <= grn_in;
         blu_ff       <= blu_in;
      end
      job_ff      <= job_in;
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      chan_ff     <= chan_in;
   end

   // The duty state doubles as the result payload.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_updated_channel = chan_ff;
   assign rsp_switch_duty     = sw_ff;
   assign rsp_brightness_duty = br_ff;
   assign rsp_red_duty        = red_ff;
   assign rsp_green_duty      = grn_ff;
   assign rsp_blue_duty       = blu_ff;

endmodule

FILE: rtl/rc_pulse_to_led_drive.sv
// RC pulse decoder that turns three receiver channels into LED duty values.
// Each transfer on the req_ side is one pin change; a rising edge records the
// start time, and a falling edge after a recorded start yields exactly one rsp_
// transfer carrying all current duties. Rising edges, unmatched falling edges and
// channel code three produce nothing. The switch channel and pulses with a fixed
// duty pass from the width register through the queue and the engine's finish
// state to the result register; a ramp (brightness or color) also passes the setup
// state and the 24-step restoring divider, which handles one pulse at a time. A
// two-entry queue lets further edges be taken while a ramp is being worked out.
// Registers are written over the csr_ port at byte address 4 times the register
// index, by the user only while the block is idle; the block does not enforce it.
module rc_pulse_to_led_drive #(
   parameter int TIME_BITS = rcpl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rcpl_pkg::CH_BITS-1:0]         req_channel,
   input  logic                                 req_level,
   input  logic [rcpl_pkg::TS_FIELD_BITS-1:0]   req_timestamp_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rcpl_pkg::CH_BITS-1:0]         rsp_updated_channel,
   output logic [rcpl_pkg::DUTY_BITS-1:0]       rsp_switch_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]       rsp_brightness_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]       rsp_red_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]       rsp_green_duty,
   output logic [rcpl_pkg::DUTY_BITS-1:0]       rsp_blue_duty,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rcpl_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [rcpl_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [rcpl_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

`include "rc_pulse_to_led_drive_assert.svh"

   rcpl_pkg::rcpl_cfg_type   cfg_ff, cfg_in;
   rcpl_pkg::rcpl_reg_type   reg_sel;
   rcpl_pkg::rcpl_qstat_type q_stat;
   rcpl_pkg::rcpl_job_type   push_job, pop_job;
   logic                     q_push, q_pop;
   logic                     csr_write;
   logic                     rsp_chan_ok;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = rcpl_pkg::rcpl_reg_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            rcpl_pkg::REG_ON_THRESHOLD: cfg_in.on_threshold = csr_pwdata[15:0];
            rcpl_pkg::REG_PULSE_MIN:    cfg_in.pulse_min    = csr_pwdata[15:0];
            rcpl_pkg::REG_PULSE_MAX:    cfg_in.pulse_max    = csr_pwdata[15:0];
            rcpl_pkg::REG_DEAD_ZONE:    cfg_in.dead_zone    = csr_pwdata[9:0];
            rcpl_pkg::REG_RED_END:      cfg_in.red_end      = csr_pwdata[15:0];
            rcpl_pkg::REG_GREEN_START:  cfg_in.green_start  = csr_pwdata[15:0];
            rcpl_pkg::REG_GREEN_END:    cfg_in.green_end    = csr_pwdata[15:0];
            rcpl_pkg::REG_BLUE_START:   cfg_in.blue_start   = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         rcpl_pkg::REG_ON_THRESHOLD: csr_prdata = 32'(cfg_ff.on_threshold);
         rcpl_pkg::REG_PULSE_MIN:    csr_prdata = 32'(cfg_ff.pulse_min);
         rcpl_pkg::REG_PULSE_MAX:    csr_prdata = 32'(cfg_ff.pulse_max);
         rcpl_pkg::REG_DEAD_ZONE:    csr_prdata = 32'(cfg_ff.dead_zone);
         rcpl_pkg::REG_RED_END:      csr_prdata = 32'(cfg_ff.red_end);
         rcpl_pkg::REG_GREEN_START:  csr_prdata = 32'(cfg_ff.green_start);
         rcpl_pkg::REG_GREEN_END:    csr_prdata = 32'(cfg_ff.green_end);
         rcpl_pkg::REG_BLUE_START:   csr_prdata = 32'(cfg_ff.blue_start);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_threshold <= rcpl_pkg::RST_ON_THRESHOLD;
         cfg_ff.pulse_min    <= rcpl_pkg::RST_PULSE_MIN;
         cfg_ff.pulse_max    <= rcpl_pkg::RST_PULSE_MAX;
         cfg_ff.dead_zone    <= rcpl_pkg::RST_DEAD_ZONE;
         cfg_ff.red_end      <= rcpl_pkg::RST_RED_END;
         cfg_ff.green_start  <= rcpl_pkg::RST_GREEN_START;
         cfg_ff.green_end    <= rcpl_pkg::RST_GREEN_END;
         cfg_ff.blue_start   <= rcpl_pkg::RST_BLUE_START;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcpl_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_level        (req_level),
      .req_timestamp_us (req_timestamp_us),
      .cfg              (cfg_ff),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   rcpl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .stat     (q_stat)
   );

   rcpl_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_stat              (q_stat),
      .q_job               (pop_job),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_updated_channel (rsp_updated_channel),
      .rsp_switch_duty     (rsp_switch_duty),
      .rsp_brightness_duty (rsp_brightness_duty),
      .rsp_red_duty        (rsp_red_duty),
      .rsp_green_duty      (rsp_green_duty),
      .rsp_blue_duty       (rsp_blue_duty)
   );

   assign rsp_chan_ok = (rsp_updated_channel == rcpl_pkg::CH_SWITCH) ||
                        (rsp_updated_channel == rcpl_pkg::CH_BRIGHTNESS) ||
                        (rsp_updated_channel == rcpl_pkg::CH_COLOR);

   `RCPL_ASSERT_NOW(a_no_push_when_full, q_push, !q_stat.full, "queue written while full")
   `RCPL_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_stat.empty, "queue read while empty")
   `RCPL_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, !q_stat.empty, "pushed job lost")
   `RCPL_ASSERT_NOW(a_result_channel_legal, rsp_valid, rsp_chan_ok, "result for unused channel")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the RC pulse to LED drive block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [rcpl_pkg::CH_BITS-1:0]   chan_type;
   typedef logic [rcpl_pkg::DUTY_BITS-1:0] duty_type;

   localparam chan_type CH_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = 128;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      chan_type channel;
      duty_type switch_duty;
      duty_type brightness_duty;
      duty_type red_duty;
      duty_type green_duty;
      duty_type blue_duty;
   } duty_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   chan_type                               req_channel = '0;
   logic                                   req_level = 1'b0;
   logic [rcpl_pkg::TS_FIELD_BITS-1:0]     req_timestamp_us = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   chan_type                               rsp_updated_channel;
   duty_type                               rsp_switch_duty;
   duty_type                               rsp_brightness_duty;
   duty_type                               rsp_red_duty;
   duty_type                               rsp_green_duty;
   duty_type                               rsp_blue_duty;
   logic                                   csr_psel = 1'b0;
   logic                                   csr_penable = 1'b0;
   logic                                   csr_pwrite = 1'b0;
   logic [rcpl_pkg::CSR_ADDR_BITS-1:0]     csr_paddr = '0;
   logic [rcpl_pkg::CSR_DATA_BITS-1:0]     csr_pwdata = '0;
   logic [rcpl_pkg::CSR_DATA_BITS-1:0]     csr_prdata;
   logic                                   csr_pready;

   // Predictor state.
   rcpl_pkg::rcpl_cfg_type settings_model;
   logic [31:0]            pulse_start [rcpl_pkg::NUM_CHANNELS];
   bit                     start_armed [rcpl_pkg::NUM_CHANNELS];
   duty_type               switch_now;
   duty_type               brightness_now;
   duty_type               color_now [rcpl_pkg::NUM_CHANNELS];
   duty_set_type           duties_expected [$];

   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  edges_taken = 0;
   int  calm_items = 0;
   int  hold_off_left = 0;
   bit  idle_enable = 1'b1;

   rc_pulse_to_led_drive uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_channel         (req_channel),
      .req_level           (req_level),
      .req_timestamp_us    (req_timestamp_us),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_updated_channel (rsp_updated_channel),
      .rsp_switch_duty     (rsp_switch_duty),
      .rsp_brightness_duty (rsp_brightness_duty),
      .rsp_red_duty        (rsp_red_duty),
      .rsp_green_duty      (rsp_green_duty),
      .rsp_blue_duty       (rsp_blue_duty),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic rcpl_pkg::rcpl_cfg_type default_setting();
      rcpl_pkg::rcpl_cfg_type c;
      c.on_threshold = rcpl_pkg::RST_ON_THRESHOLD;
      c.pulse_min    = rcpl_pkg::RST_PULSE_MIN;
      c.pulse_max    = rcpl_pkg::RST_PULSE_MAX;
      c.dead_zone    = rcpl_pkg::RST_DEAD_ZONE;
      c.red_end      = rcpl_pkg::RST_RED_END;
      c.green_start  = rcpl_pkg::RST_GREEN_START;
      c.green_end    = rcpl_pkg::RST_GREEN_END;
      c.blue_start   = rcpl_pkg::RST_BLUE_START;
      return c;
   endfunction

   function automatic logic [31:0] cfg_field(input rcpl_pkg::rcpl_cfg_type c,
                                             input rcpl_pkg::rcpl_reg_type idx);
      case (idx)
         rcpl_pkg::REG_ON_THRESHOLD: return 32'(c.on_threshold);
         rcpl_pkg::REG_PULSE_MIN:    return 32'(c.pulse_min);
         rcpl_pkg::REG_PULSE_MAX:    return 32'(c.pulse_max);
         rcpl_pkg::REG_DEAD_ZONE:    return 32'(c.dead_zone);
         rcpl_pkg::REG_RED_END:      return 32'(c.red_end);
         rcpl_pkg::REG_GREEN_START:  return 32'(c.green_start);
         rcpl_pkg::REG_GREEN_END:    return 32'(c.green_end);
         rcpl_pkg::REG_BLUE_START:   return 32'(c.blue_start);
         default:                    return '0;
      endcase
   endfunction

   function automatic longint linear_ramp(input longint x, input longint a, input longint b,
                                          input longint c, input longint d);
      longint den;
      longint q;
      den = b - a;
      q = 0;
      if (den != 0)
         q = ((x - a) * (d - c)) / den;
      return q + c;
   endfunction

   function automatic duty_type clamp_duty(input longint v);
      if (v < 0)
         return rcpl_pkg::DUTY_OFF;
      if (v > 255)
         return rcpl_pkg::DUTY_FULL;
      return v[rcpl_pkg::DUTY_BITS-1:0];
   endfunction

   // Applies one accepted pin change to the predictor and queues the duties
   // for completed pulses.
   task automatic predict_edge(input chan_type ch, input logic lvl, input logic [31:0] ts);
      logic [31:0] diff;
      longint w, thr, pmin, pmax, dz, re, gs, ge, bs, mid, r, g, b;
      duty_set_type d;
      if (ch == CH_UNUSED)
         return;
      if (lvl) begin
         pulse_start[ch] = ts;
         start_armed[ch] = 1'b1;
         return;
      end
      if (!start_armed[ch])
         return;
      start_armed[ch] = 1'b0;
      diff = ts - pulse_start[ch];
      w = (diff > 32'(rcpl_pkg::WIDTH_MAX)) ? longint'(rcpl_pkg::WIDTH_MAX) : longint'(diff);
      thr  = longint'(settings_model.on_threshold);
      pmin = longint'(settings_model.pulse_min);
      pmax = longint'(settings_model.pulse_max);
      dz   = longint'(settings_model.dead_zone);
      re   = longint'(settings_model.red_end);
      gs   = longint'(settings_model.green_start);
      ge   = longint'(settings_model.green_end);
      bs   = longint'(settings_model.blue_start);
      if (ch == rcpl_pkg::CH_SWITCH) begin
         switch_now = (w > thr) ? rcpl_pkg::DUTY_FULL : rcpl_pkg::DUTY_OFF;
      end else if (ch == rcpl_pkg::CH_BRIGHTNESS) begin
         if (w <= pmin + dz)
            brightness_now = rcpl_pkg::DUTY_OFF;
         else
            brightness_now = clamp_duty(linear_ramp(w, pmin, pmax, 0, 255));
      end else begin
         r = 0;
         g = 0;
         b = 0;
         mid = (gs + ge) / 2;
         if (w <= re) begin
            r = linear_ramp(w, pmin, re, 255, 0);
         end else if (w <= ge) begin
            if (w <= mid)
               g = linear_ramp(w, gs, mid, 0, 255);
            else
               g = linear_ramp(w, mid, ge, 255, 0);
         end else if (w <= pmax) begin
            b = linear_ramp(w, bs, pmax, 0, 255);
         end
         color_now[0] = clamp_duty(r);
         color_now[1] = clamp_duty(g);
         color_now[2] = clamp_duty(b);
      end
      d.channel         = ch;
      d.switch_duty     = switch_now;
      d.brightness_duty = brightness_now;
      d.red_duty        = color_now[0];
      d.green_duty      = color_now[1];
      d.blue_duty       = color_now[2];
      duties_expected.push_back(d);
   endtask

   // Offers one pin change and holds it until the transfer completes.
   task automatic send_edge(input chan_type ch, input logic lvl, input logic [31:0] ts);
      int gap;
      if (idle_enable && calm_items == 0 && $urandom_range(0, 5) == 0) begin
         gap = int'($urandom_range(1, 11));
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         if ($urandom_range(0, 3) == 0)
            calm_items = int'($urandom_range(10, 40));
      end else if (calm_items > 0) begin
         calm_items--;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_channel      <= ch;
      req_level        <= lvl;
      req_timestamp_us <= ts;
      do @(posedge clock); while (req_stall);
      predict_edge(ch, lvl, ts);
      edges_taken++;
   endtask

   task automatic send_pulse(input chan_type ch, input logic [31:0] t0, input logic [31:0] w);
      send_edge(ch, 1'b1, t0);
      send_edge(ch, 1'b0, t0 + w);
   endtask

   task automatic wait_drained();
      while (duties_expected.size() != 0)
         @(posedge clock);
   endtask

   // Brings the block to rest before registers are touched.
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input rcpl_pkg::rcpl_reg_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         rcpl_pkg::REG_ON_THRESHOLD:
            settings_model.on_threshold = value[rcpl_pkg::WIDTH_BITS-1:0];
         rcpl_pkg::REG_PULSE_MIN:
            settings_model.pulse_min    = value[rcpl_pkg::WIDTH_BITS-1:0];
         rcpl_pkg::REG_PULSE_MAX:
            settings_model.pulse_max    = value[rcpl_pkg::WIDTH_BITS-1:0];
         rcpl_pkg::REG_DEAD_ZONE:
            settings_model.dead_zone    = value[rcpl_pkg::DZ_BITS-1:0];
         rcpl_pkg::REG_RED_END:
            settings_model.red_end      = value[rcpl_pkg::WIDTH_BITS-1:0];
         rcpl_pkg::REG_GREEN_START:
            settings_model.green_start  = value[rcpl_pkg::WIDTH_BITS-1:0];
         rcpl_pkg::REG_GREEN_END:
            settings_model.green_end    = value[rcpl_pkg::WIDTH_BITS-1:0];
         rcpl_pkg::REG_BLUE_START:
            settings_model.blue_start   = value[rcpl_pkg::WIDTH_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input rcpl_pkg::rcpl_reg_type idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== cfg_field(settings_model, idx))
         report_mismatch($sformatf("register %s readback", idx.name()),
                         csr_prdata, cfg_field(settings_model, idx));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_setting(input rcpl_pkg::rcpl_cfg_type c);
      settle_idle();
      for (int i = int'(rcpl_pkg::REG_ON_THRESHOLD); i <= int'(rcpl_pkg::REG_BLUE_START); i++)
         csr_write(rcpl_pkg::rcpl_reg_type'(i), cfg_field(c, rcpl_pkg::rcpl_reg_type'(i)));
      for (int i = int'(rcpl_pkg::REG_ON_THRESHOLD); i <= int'(rcpl_pkg::REG_BLUE_START); i++)
         csr_read_check(rcpl_pkg::rcpl_reg_type'(i));
   endtask

   function automatic rcpl_pkg::rcpl_cfg_type random_setting(input bit ordered);
      rcpl_pkg::rcpl_cfg_type c;
      int lo;
      int span;
      lo = int'($urandom_range(0, 4000));
      span = int'($urandom_range(6, 3000));
      if (ordered) begin
         c.pulse_min    = 16'(lo);
         c.pulse_max    = 16'(lo + span);
         c.red_end      = 16'(lo + span / 3);
         c.green_start  = 16'(lo + span / 3 + 1);
         c.green_end    = 16'(lo + 2 * span / 3);
         c.blue_start   = 16'(lo + 2 * span / 3 + 1);
         c.on_threshold = 16'(lo + int'($urandom_range(0, span)));
         c.dead_zone    = 10'(int'($urandom_range(0, 1023)) % (span / 4 + 1));
      end else begin
         c.on_threshold = 16'($urandom);
         c.pulse_min    = 16'($urandom);
         c.pulse_max    = 16'($urandom);
         c.dead_zone    = 10'($urandom);
         c.red_end      = 16'($urandom);
         c.green_start  = 16'($urandom);
         c.green_end    = 16'($urandom);
         c.blue_start   = 16'($urandom);
      end
      return c;
   endfunction

   // Pulse widths cluster around the current breakpoints, with some wide
   // values that exercise saturation.
   function automatic logic [31:0] pick_width();
      int base;
      base = 0;
      case ($urandom_range(0, 11))
         0: base = int'(settings_model.on_threshold);
         1: base = int'(settings_model.pulse_min);
         2: base = int'(settings_model.pulse_min) + int'(settings_model.dead_zone);
         3: base = int'(settings_model.pulse_max);
         4: base = int'(settings_model.red_end);
         5: base = int'(settings_model.green_start);
         6: base = (int'(settings_model.green_start) + int'(settings_model.green_end)) / 2;
         7: base = int'(settings_model.green_end);
         8: base = int'(settings_model.blue_start);
         9: return $urandom;
         default: return 32'($urandom_range(0, 65535));
      endcase
      return 32'(base + int'($urandom_range(0, 6)) - 3);
   endfunction

   // Mostly complete pulses with random content, the rest stray edges.
   task automatic run_pulses(input int count);
      int first;
      chan_type ch;
      chan_type other;
      logic [31:0] t0;
      logic [31:0] t1;
      first = edges_taken;
      while (edges_taken - first < count) begin
         if ($urandom_range(0, 99) < 75) begin
            ch = chan_type'($urandom_range(0, 2));
            t0 = $urandom;
            send_edge(ch, 1'b1, t0);
            if ($urandom_range(0, 3) == 0) begin
               other = chan_type'((int'(ch) + int'($urandom_range(1, 2))) %
                                  rcpl_pkg::NUM_CHANNELS);
               t1 = $urandom;
               send_pulse(other, t1, pick_width());
            end
            if ($urandom_range(0, 9) == 0) begin
               t0 = t0 + $urandom_range(0, 5000);
               send_edge(ch, 1'b1, t0);
            end
            send_edge(ch, 1'b0, t0 + pick_width());
            if ($urandom_range(0, 9) == 0)
               send_edge(ch, 1'b0, $urandom);
         end else begin
            send_edge(chan_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
         end
      end
   endtask

   task automatic test_directed_defaults();
      for (int i = int'(rcpl_pkg::REG_ON_THRESHOLD); i <= int'(rcpl_pkg::REG_BLUE_START); i++)
         csr_read_check(rcpl_pkg::rcpl_reg_type'(i));
      send_pulse(rcpl_pkg::CH_SWITCH, 32'd1000, 32'(rcpl_pkg::RST_ON_THRESHOLD));
      send_pulse(rcpl_pkg::CH_SWITCH, 32'd5000, 32'(rcpl_pkg::RST_ON_THRESHOLD) + 32'd1);
      send_pulse(rcpl_pkg::CH_BRIGHTNESS, 32'd0,
                 32'(rcpl_pkg::RST_PULSE_MIN) + 32'(rcpl_pkg::RST_DEAD_ZONE));
      send_pulse(rcpl_pkg::CH_BRIGHTNESS, 32'd9000, 32'(rcpl_pkg::RST_PULSE_MAX) + 32'd500);
      send_pulse(rcpl_pkg::CH_COLOR, 32'd100, 32'(rcpl_pkg::RST_RED_END));
      send_pulse(rcpl_pkg::CH_COLOR, 32'd200,
                 (32'(rcpl_pkg::RST_GREEN_START) + 32'(rcpl_pkg::RST_GREEN_END)) / 32'd2);
      send_pulse(rcpl_pkg::CH_COLOR, 32'd300, 32'(rcpl_pkg::RST_PULSE_MAX));
      send_pulse(rcpl_pkg::CH_COLOR, 32'd400, 32'(rcpl_pkg::RST_PULSE_MAX) + 32'd1);
      // The unused channel code and a falling edge with no start do nothing.
      send_edge(CH_UNUSED, 1'b1, 32'hA5A5_5A5A);
      send_edge(rcpl_pkg::CH_BRIGHTNESS, 1'b0, 32'd12345);
      // A second rising edge restarts the measurement.
      send_edge(rcpl_pkg::CH_COLOR, 1'b1, 32'd10000);
      send_edge(rcpl_pkg::CH_COLOR, 1'b1, 32'd10500);
      send_edge(rcpl_pkg::CH_COLOR, 1'b0, 32'd10500 + 32'(rcpl_pkg::RST_GREEN_END));
      // Counter wrap, then an over-long pulse that saturates the width.
      send_pulse(rcpl_pkg::CH_SWITCH, 32'hFFFF_F9C0, 32'd2000);
      send_pulse(rcpl_pkg::CH_BRIGHTNESS, 32'd0, 32'hFFFF_FFFF);
   endtask

   task automatic test_setting_extremes();
      apply_setting('0);
      run_pulses(120);
      apply_setting('1);
      run_pulses(120);
      apply_setting(default_setting());
      run_pulses(200);
   endtask

   task automatic test_random_settings();
      apply_setting(random_setting(1'b1));
      run_pulses(150);
      apply_setting(random_setting(1'b0));
      run_pulses(150);
      apply_setting(random_setting(1'b1));
      run_pulses(150);
   endtask

   task automatic test_backpressure();
      apply_setting(default_setting());
      hold_off_left = HOLD_OFF_LEN;
      run_pulses(60);
      wait_drained();
      run_pulses(60);
   endtask

   task automatic test_quiet_tail();
      apply_setting(random_setting(1'b1));
      idle_enable = 1'b0;
      run_pulses(140);
   endtask

   initial begin : receiver_idling
      int burst;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else if (idle_enable && $urandom_range(0, 6) == 0) begin
            burst = int'($urandom_range(1, 11));
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
            if ($urandom_range(0, 3) == 0) begin
               @(negedge clock);
               rsp_stall <= 1'b0;
               repeat ($urandom_range(20, 80)) @(negedge clock);
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      duty_set_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (duties_expected.size() == 0) begin
               report_mismatch("result transfer with nothing expected, channel",
                               rsp_updated_channel, -1);
            end else begin
               want = duties_expected.pop_front();
               if (rsp_updated_channel !== want.channel)
                  report_mismatch("updated_channel", rsp_updated_channel, want.channel);
               if (rsp_switch_duty !== want.switch_duty)
                  report_mismatch("switch_duty", rsp_switch_duty, want.switch_duty);
               if (rsp_brightness_duty !== want.brightness_duty)
                  report_mismatch("brightness_duty", rsp_brightness_duty,
                                  want.brightness_duty);
               if (rsp_red_duty !== want.red_duty)
                  report_mismatch("red_duty", rsp_red_duty, want.red_duty);
               if (rsp_green_duty !== want.green_duty)
                  report_mismatch("green_duty", rsp_green_duty, want.green_duty);
               if (rsp_blue_duty !== want.blue_duty)
                  report_mismatch("blue_duty", rsp_blue_duty, want.blue_duty);
            end
         end
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      settings_model = default_setting();
      switch_now = rcpl_pkg::DUTY_OFF;
      brightness_now = rcpl_pkg::DUTY_OFF;
      for (int i = 0; i < rcpl_pkg::NUM_CHANNELS; i++) begin
         pulse_start[i] = '0;
         start_armed[i] = 1'b0;
         color_now[i] = rcpl_pkg::DUTY_OFF;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_setting_extremes();
      test_random_settings();
      test_backpressure();
      test_quiet_tail();
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (duties_expected.size() != 0)
         report_mismatch("results still outstanding", 0, duties_expected.size());
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
